// File: hw/rtl/slpst_pkg.sv
// Shared types, codes and default sizes for the scoped symbol table unit.
// No dependencies; the probe unit, the top level and the bench import this package.
package slpst_pkg;

   localparam int SLOTS_DEF      = 16;
   localparam int LEVELS_DEF     = 8;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   // fixed field widths of the channels
   localparam int FIELD_W  = 32;
   localparam int LEVEL_W  = 3;
   localparam int STATUS_W = 3;

   // home slot is taken from the key above this bit
   localparam int HASH_SHIFT = 3;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_BIND   = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_OVERFLOW  = 3'd3,
      STAT_UNDERFLOW = 3'd4,
      STAT_BAD_KEY   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_FILL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic hit;
      logic empty;
      logic last;
   } probe_flags_type;

endpackage

// File: hw/rtl/slpst_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; used by the top level of the symbol table unit.
interface slpst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] key;
   logic [31:0] value;

   modport source (output valid, req_type, key, value, input ready);
   modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface slpst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] found_value;
   logic [2:0]  found_level;

   modport source (output valid, status, found_value, found_level, input ready);
   modport sink   (input valid, status, found_value, found_level, output ready);
endinterface

// File: hw/rtl/slpst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the slot table and the saved fill counts.
module slpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/slpst_probe.sv
// Probe step unit: compares one slot's key and computes the next probe slot.
// Depends on slpst_pkg for the flag struct.
module slpst_probe #(
   parameter int KEY_W = 32,
   parameter int SLOTS = 16,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic [KEY_W-1:0]             slot_key,
   input  logic [KEY_W-1:0]             probe_key,
   input  logic [SLOT_W-1:0]            idx,
   input  logic [SLOT_W-1:0]            cnt,
   output slpst_pkg::probe_flags_type   flags,
   output logic [SLOT_W-1:0]            next_idx
);
   import slpst_pkg::*;

   // a stored key of zero marks a free slot
   assign flags.empty = (slot_key == '0);
   assign flags.hit   = (slot_key == probe_key);
   assign flags.last  = (cnt == SLOT_W'(SLOTS - 1));

   // wrap at the table size
   assign next_idx = idx + 1'b1;

endmodule

// File: hw/rtl/scoped_linear_probe_symbol_table_unit.sv
// Scoped symbol table with linear probing: a stack of hash-table scopes
// in one slot RAM, walked by a probe sequencer. Depends on slpst_pkg,
// slpst_if, slpst_ram and slpst_probe.
//
// Usage: send one request word on req (push, pop, bind, lookup with key and
// value); exactly one response word comes back on rsp with status, the found
// value and the found level. One request is in work at a time; req.ready is
// high while the sequencer is idle, also while an earlier response still
// waits in the output register.
// A push clears the new scope's slots, one per cycle. Bind and lookup read
// at most SLOTS slots per scope; a lookup walks the scopes from the top
// down, so a deep miss costs up to LEVELS*SLOTS reads. The slot RAM's
// single read port allows one probed slot per cycle.
// Reset: the sequencer clears the SLOTS slots of level 0, one per cycle,
// and holds req.ready low until they are cleared.
// Stall: a response held by rsp.ready low stays in the output register; the
// next request is still accepted and worked, and its result waits until the
// register frees.
// SLOTS must be a power of two.
module scoped_linear_probe_symbol_table_unit #(
   parameter int SLOTS      = slpst_pkg::SLOTS_DEF,
   parameter int LEVELS     = slpst_pkg::LEVELS_DEF,
   parameter int KEY_BITS   = slpst_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = slpst_pkg::VALUE_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   slpst_req_if.sink   req,
   slpst_rsp_if.source rsp
);
   import slpst_pkg::*;

   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int KEY_W      = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
   localparam int VAL_W      = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
   localparam int FILL_W     = $clog2(SLOTS / 2 + 1);
   localparam int ENTRY_W    = KEY_W + VAL_W;
   localparam int ADDR_W     = LVL_W + SLOT_W;
   localparam int TBL_DEPTH  = (2 ** LVL_W) * SLOTS;
   localparam int FILL_DEPTH = 2 ** LVL_W;

   // sequencer and request registers
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   logic [SLOT_W-1:0]      home_ff, home_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic [LVL_W-1:0]       top_ff, top_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [SLOT_W-1:0]      clr_ff, clr_in;
   logic                   clr_reply_ff, clr_reply_in;

   // pending result and output register
   status_type             res_status_ff, res_status_in;
   logic [FIELD_W-1:0]     res_fval_ff, res_fval_in;
   logic [LEVEL_W-1:0]     res_flev_ff, res_flev_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]     rsp_fval_ff, rsp_fval_in;
   logic [LEVEL_W-1:0]     rsp_flev_ff, rsp_flev_in;

   // memory ports
   logic                   tbl_we;
   logic [ADDR_W-1:0]      tbl_wa, tbl_ra;
   logic [ENTRY_W-1:0]     tbl_wd, tbl_rd;
   logic                   fill_we;
   logic [LVL_W-1:0]       fill_wa, fill_ra;
   logic [FILL_W-1:0]      fill_wd, fill_rd;

   // decode helpers
   logic                   accept;
   op_type                 req_op;
   logic [KEY_W-1:0]       req_key_m;
   logic [SLOT_W-1:0]      req_home;
   logic                   top_max, top_zero, fill_full, out_free;
   logic                   clr_last;
   logic [KEY_W-1:0]       rd_key;
   logic [VAL_W-1:0]       rd_val;
   logic [VAL_W+FIELD_W-1:0] rd_val_ext;
   logic [LVL_W+LEVEL_W-1:0] lvl_ext;
   probe_flags_type        pf;
   logic [SLOT_W-1:0]      next_idx;

   assign req.ready  = (state_ff == S_IDLE);
   assign accept     = req.valid && req.ready;
   assign req_op     = op_type'(req.req_type);
   assign req_key_m  = req.key[KEY_W-1:0];
   assign req_home   = SLOT_W'(req_key_m >> HASH_SHIFT);
   assign top_max    = (top_ff == LVL_W'(LEVELS - 1));
   assign top_zero   = (top_ff == '0);
   assign fill_full  = (fill_ff >= FILL_W'(SLOTS / 2));
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign clr_last   = (clr_ff == SLOT_W'(SLOTS - 1));
   assign rd_key     = tbl_rd[ENTRY_W-1:VAL_W];
   assign rd_val     = tbl_rd[VAL_W-1:0];
   assign rd_val_ext = {{FIELD_W{1'b0}}, rd_val};
   assign lvl_ext    = {{LEVEL_W{1'b0}}, lvl_ff};

   // key/value slots of all scopes; a zero key marks a free slot
   slpst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TBL_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   // fill counts of the scopes below the top one
   slpst_ram #(
      .WIDTH (FILL_W),
      .DEPTH (FILL_DEPTH)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_addr (fill_ra),
      .rd_data (fill_rd)
   );

   // shared compare / next-slot unit, one probe step per cycle
   slpst_probe #(
      .KEY_W (KEY_W),
      .SLOTS (SLOTS)
   ) u_probe (
      .slot_key  (rd_key),
      .probe_key (key_ff),
      .idx       (idx_ff),
      .cnt       (cnt_ff),
      .flags     (pf),
      .next_idx  (next_idx)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_op) inside
                  OP_PUSH:           state_in = top_max ? S_DONE : S_CLEAR;
                  OP_POP:            state_in = top_zero ? S_DONE : S_FILL;
                  OP_BIND, OP_LOOKUP: state_in = (req_key_m == '0) ? S_DONE : S_PROBE;
               endcase
            end
         end
         S_PROBE: begin
            if (pf.hit) begin
               state_in = S_DONE;
            end else if (pf.empty || pf.last) begin
               // a lookup miss drops to the next scope down
               if (!(op_ff == OP_LOOKUP && lvl_ff != '0)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_FILL: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      home_in       = home_ff;
      lvl_in        = lvl_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      fill_in       = fill_ff;
      clr_in        = clr_ff;
      clr_reply_in  = clr_reply_ff;
      res_status_in = res_status_ff;
      res_fval_in   = res_fval_ff;
      res_flev_in   = res_flev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_flev_in   = rsp_flev_ff;
      tbl_we        = 1'b0;
      tbl_wa        = {lvl_ff, idx_ff};
      tbl_wd        = {key_ff, val_ff};
      tbl_ra        = {lvl_ff, idx_ff};
      fill_we       = 1'b0;
      fill_wa       = top_ff;
      fill_wd       = fill_ff;
      fill_ra       = top_ff - 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            // free one slot of the top scope per cycle
            tbl_we = 1'b1;
            tbl_wa = {top_ff, clr_ff};
            tbl_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               clr_reply_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               key_in        = req_key_m;
               val_in        = req.value[VAL_W-1:0];
               home_in       = req_home;
               lvl_in        = top_ff;
               idx_in        = req_home;
               cnt_in        = '0;
               tbl_ra        = {top_ff, req_home};
               res_status_in = STAT_OK;
               res_fval_in   = '0;
               res_flev_in   = '0;
               unique case (req_op) inside
                  OP_PUSH: begin
                     if (top_max) begin
                        res_status_in = STAT_OVERFLOW;
                     end else begin
                        // save the current fill, open an empty scope
                        fill_we      = 1'b1;
                        top_in       = top_ff + 1'b1;
                        fill_in      = '0;
                        clr_in       = '0;
                        clr_reply_in = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (top_zero) begin
                        res_status_in = STAT_UNDERFLOW;
                     end else begin
                        top_in = top_ff - 1'b1;
                     end
                  end
                  OP_BIND, OP_LOOKUP: begin
                     if (req_key_m == '0) begin
                        res_status_in = STAT_BAD_KEY;
                     end
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (pf.hit) begin
               if (op_ff == OP_BIND) begin
                  tbl_we = 1'b1;
               end else begin
                  res_fval_in = rd_val_ext[FIELD_W-1:0];
                  res_flev_in = lvl_ext[LEVEL_W-1:0];
               end
            end else if (pf.empty || pf.last) begin
               if (op_ff == OP_BIND) begin
                  if (fill_full || !pf.empty) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     tbl_we  = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (lvl_ff == '0) begin
                  res_status_in = STAT_NOT_FOUND;
               end else begin
                  lvl_in = lvl_ff - 1'b1;
                  idx_in = home_ff;
                  cnt_in = '0;
                  tbl_ra = {lvl_ff - 1'b1, home_ff};
               end
            end else begin
               // advance to the next slot of this scope
               idx_in = next_idx;
               cnt_in = cnt_ff + 1'b1;
               tbl_ra = {lvl_ff, next_idx};
            end
         end
         S_FILL: begin
            fill_in = fill_rd;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fval_in   = res_fval_ff;
               rsp_flev_in   = res_flev_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         top_ff       <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      home_ff       <= home_in;
      lvl_ff        <= lvl_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_fval_ff   <= res_fval_in;
      res_flev_ff   <= res_flev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_flev_ff   <= rsp_flev_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_value = rsp_fval_ff;
   assign rsp.found_level = rsp_flev_ff;

`ifndef NO_ASSERTIONS
   // a push that fits raises the top scope by one
   a_push_raises_top: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_PUSH && !top_max) |=> top_ff == LVL_W'($past(top_ff) + 1'b1))
      else $error("push did not raise the top scope");

   // the probe never looks above the top scope
   a_probe_below_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> lvl_ff <= top_ff)
      else $error("probe level above top scope");

   // a scope being cleared starts empty
   a_clear_fill_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> fill_ff == '0)
      else $error("fill count not zero while clearing");

   // only a bind writes slots during a probe
   a_probe_write_bind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && tbl_we) |-> op_ff == OP_BIND && lvl_ff == top_ff)
      else $error("slot write outside a bind on the top scope");
`endif

endmodule

// File: dv/scoped_linear_probe_symbol_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the scoped symbol table unit: a scoreboard class
// predicts every response word. Depends on slpst_pkg, slpst_if and the RTL.
module scoped_linear_probe_symbol_table_unit_tb;
   import slpst_pkg::*;

   localparam int SLOTS        = SLOTS_DEF;
   localparam int LEVELS       = LEVELS_DEF;
   localparam int SLOT_TOTAL   = SLOTS * LEVELS;
   localparam int IDLE_PCT     = 21;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_WORDS = 1120;
   localparam int POOL_N       = 24;
   // quiet stretch: no idling on either side while this many words are in
   localparam int QUIET_FROM   = 600;
   localparam int QUIET_TO     = 800;
   // long receiver hold-off, started once this many words are in
   localparam int HOLD_AT      = 320;
   localparam int HOLD_CYCLES  = 400;
   // a deep lookup miss reads up to LEVELS*SLOTS slots; the hold-off dominates
   localparam int STALL_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 2 * SLOT_TOTAL + 16;

   typedef struct {
      status_type           status;
      logic [FIELD_W-1:0]   found_value;
      logic [LEVEL_W-1:0]   found_level;
   } reply_type;

   // Scoreboard: holds its own copy of the scope stack and a queue of the
   // response words still owed by the block.
   class symtab_scoreboard_type;
      logic [FIELD_W-1:0] key_at[SLOT_TOTAL];
      logic [FIELD_W-1:0] value_at[SLOT_TOTAL];
      bit                 held[SLOT_TOTAL];
      int unsigned        fill_count[LEVELS];
      int unsigned        cur_level;
      reply_type          replies_due[$];
      int                 errors;
      int                 status_seen[6];

      function new();
         foreach (held[i]) held[i] = 1'b0;
         foreach (fill_count[i]) fill_count[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         cur_level = 0;
         errors = 0;
      endfunction

      // Walk one scope from the home slot; pos is the hit, the first free slot or SLOTS.
      function bit find_in_level(int unsigned lvl, logic [FIELD_W-1:0] k,
                                 output int unsigned pos);
         int unsigned i;
         int unsigned a;
         i = (k >> HASH_SHIFT) & (SLOTS - 1);
         for (int n = 0; n < SLOTS; n++) begin
            a = lvl * SLOTS + i;
            if (!held[a]) begin
               pos = i;
               return 1'b0;
            end
            if (key_at[a] == k) begin
               pos = i;
               return 1'b1;
            end
            i = (i + 1) % SLOTS;
         end
         pos = SLOTS;
         return 1'b0;
      endfunction

      function reply_type resolve_request(op_type op, logic [FIELD_W-1:0] k,
                                          logic [FIELD_W-1:0] v);
         reply_type   r;
         int unsigned pos;
         int unsigned lvl;
         int unsigned a;
         r.status = STAT_OK;
         r.found_value = '0;
         r.found_level = '0;
         case (op)
            OP_PUSH: begin
               if (cur_level + 1 >= LEVELS) r.status = STAT_OVERFLOW;
               else cur_level++;
            end
            OP_POP: begin
               if (cur_level == 0) begin
                  r.status = STAT_UNDERFLOW;
               end else begin
                  for (int i = 0; i < SLOTS; i++) held[cur_level * SLOTS + i] = 1'b0;
                  fill_count[cur_level] = 0;
                  cur_level--;
               end
            end
            default: begin
               if (k == '0) begin
                  r.status = STAT_BAD_KEY;
               end else if (op == OP_BIND) begin
                  if (find_in_level(cur_level, k, pos)) begin
                     value_at[cur_level * SLOTS + pos] = v;
                  end else if (fill_count[cur_level] >= SLOTS / 2 || pos >= SLOTS) begin
                     r.status = STAT_FULL;
                  end else begin
                     a = cur_level * SLOTS + pos;
                     key_at[a] = k;
                     value_at[a] = v;
                     held[a] = 1'b1;
                     fill_count[cur_level]++;
                  end
               end else begin
                  r.status = STAT_NOT_FOUND;
                  lvl = cur_level + 1;
                  while (lvl > 0) begin
                     lvl--;
                     if (find_in_level(lvl, k, pos)) begin
                        r.status = STAT_OK;
                        r.found_value = value_at[lvl * SLOTS + pos];
                        r.found_level = LEVEL_W'(lvl);
                        break;
                     end
                  end
               end
            end
         endcase
         return r;
      endfunction

      function void note_request(op_type op, logic [FIELD_W-1:0] k,
                                 logic [FIELD_W-1:0] v);
         replies_due.push_back(resolve_request(op, k, v));
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [FIELD_W-1:0] fv,
                                   logic [LEVEL_W-1:0] fl);
         reply_type want;
         if (replies_due.size() == 0) begin
            $error("response word with nothing pending: status %0d", st);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         if (int'(want.status) < 6) status_seen[int'(want.status)]++;
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
         end
         if (fv !== want.found_value) begin
            $error("found_value: expected %h, actual %h", want.found_value, fv);
            errors++;
         end
         if (fl !== want.found_level) begin
            $error("found_level: expected %0d, actual %0d", want.found_level, fl);
            errors++;
         end
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   slpst_req_if req_ch ();
   slpst_rsp_if rsp_ch ();

   symtab_scoreboard_type sb = new();

   int words_in    = 0;
   int words_out   = 0;
   int quiet_count = 0;

   logic [FIELD_W-1:0] key_pool[POOL_N];

   scoped_linear_probe_symbol_table_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #1 clock = ~clock;

   function automatic bit quiet_stretch();
      return words_in >= QUIET_FROM && words_in < QUIET_TO;
   endfunction

   // Monitor both channels on the edge; predict on accept, check on accept.
   // Count edges with no handshake at all for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(op_type'(req_ch.req_type), req_ch.key, req_ch.value);
            words_in <= words_in + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_response(rsp_ch.status, rsp_ch.found_value, rsp_ch.found_level);
            words_out <= words_out + 1;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_count <= 0;
         else
            quiet_count <= quiet_count + 1;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      wait (quiet_count >= STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Receiver: random back-pressure, except in the quiet stretch; once, hold
   // ready low long enough that the block fills up and stalls its input.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && words_in >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offer one request word and hold it until the block takes it. Idle
   // cycles go in front of the word, so valid never drops and rises in one step.
   task automatic send_word(input op_type op, input logic [FIELD_W-1:0] k,
                            input logic [FIELD_W-1:0] v);
      while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.key      <= k;
      req_ch.value    <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      op_type             op;
      logic [FIELD_W-1:0] k;
      logic [FIELD_W-1:0] v;
      logic [3:0]         home;
      int                 pick;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= OP_PUSH;
      req_ch.key      <= '0;
      req_ch.value    <= '0;

      // Build a key pool crowded around the slot wrap (home slots 13..2),
      // so that probes collide, wrap and scopes run full.
      foreach (key_pool[i]) begin
         home = 4'(13 + $urandom_range(5));
         key_pool[i] = {25'($urandom()), home, 3'($urandom())};
         if (key_pool[i] == '0) key_pool[i] = 32'h80;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: bad keys, underflow, shadowing, a full scope with a
      // wrapped probe, overwrite while full, pop, and overflow at the top.
      send_word(OP_POP,    32'h0, 32'h0);
      send_word(OP_BIND,   32'h0, 32'hFFFF_FFFF);
      send_word(OP_LOOKUP, 32'h0, 32'h0);
      send_word(OP_BIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_BIND,   32'hFFFF_FFFF, 32'h0);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      // fill level 1: all keys home on the last slot and wrap to the front
      for (int j = 1; j < SLOTS / 2; j++)
         send_word(OP_BIND, 32'h78 | (j << 8), 32'h1000 + j);
      send_word(OP_BIND,   32'h79, 32'h5555_5555);
      send_word(OP_BIND,   32'h178, 32'hAAAA_AAAA);
      send_word(OP_LOOKUP, 32'h778, 32'h0);
      send_word(OP_LOOKUP, 32'h79, 32'h0);
      send_word(OP_POP,    32'h0, 32'h0);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      for (int j = 0; j < LEVELS; j++)
         send_word(OP_PUSH, 32'h0, 32'h0);
      send_word(OP_LOOKUP, 32'h8000_0000, 32'h0);

      // Random part: mostly pool keys, so binds land in crowded scopes and
      // lookups hit across levels; the rest is arbitrary keys and zero keys.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(99);
         if (pick < 12)      op = OP_PUSH;
         else if (pick < 23) op = OP_POP;
         else if (pick < 61) op = OP_BIND;
         else                op = OP_LOOKUP;
         k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_N - 1)]
                                       : 32'($urandom());
         if ($urandom_range(99) < 3) k = '0;
         pick = $urandom_range(99);
         if (pick < 4)      v = '0;
         else if (pick < 8) v = '1;
         else               v = 32'($urandom());
         send_word(op, k, v);
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for every owed word, then a tail for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d request words and %0d response words", words_in, words_out);
      $display("statuses: ok %0d, not found %0d, full %0d, overflow %0d, underflow %0d, bad key %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
